/* src/pbra_pkg.sv */
// Shared constants and types for the page bitmap refcount allocator.
package pbra_pkg;

	localparam int PAGE_TOTAL = 4096;
	localparam int PAGE_W     = 12;
	localparam int MAP_BITS   = 32;
	localparam int BIT_W      = 5;
	localparam int MAP_WORDS  = PAGE_TOTAL / MAP_BITS;
	localparam int WORD_W     = PAGE_W - BIT_W;
	localparam int GRP_N      = MAP_WORDS / MAP_BITS;
	localparam int GRP_W      = WORD_W - BIT_W;
	localparam int COUNT_W    = 8;
	localparam int FREE_W     = 13;
	localparam int MODE_W     = 3;
	localparam int STATUS_W   = 2;

	localparam int IN_DATA_W  = 16;
	localparam int IN_USER_W  = MODE_W;
	localparam int OUT_DATA_W = 40;
	localparam int OUT_USER_W = STATUS_W;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

	localparam logic [MODE_W-1:0] MODE_ALLOC   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_REF     = 3'd1;
	localparam logic [MODE_W-1:0] MODE_UNREF   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_AVAIL   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_RESERVE = 3'd4;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NOMEM = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_UNDER = 2'd2;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_AGRP  = 6'b000100,
		ST_AWORD = 6'b001000,
		ST_AWR   = 6'b010000,
		ST_RMW   = 6'b100000
	} state_t;

endpackage

/* src/page_bitmap_refcount_allocator.sv */
// Top level of the page bitmap refcount allocator.
//
//  channel | direction | tdata (low bit up)                               | tuser
//  --------+-----------+--------------------------------------------------+-------------
//  s_*     | in        | page_index[11:0], zero fill [15:12]              | mode[2:0]
//  m_*     | out       | result_page[11:0], ref_count[19:12],             | status[1:0]
//          |           | free_pages[32:20], zero fill [39:33]             |
//
// One beat is handled at a time. Reference, drop, make-available, reserve and
// unknown modes read the memories, then write back; alloc picks a group, then
// picks a word and reads the map, then writes back; memory reads are registered.
// After reset a clearing pass writes every count to 255 and every map word to
// zero; s_tready stays low until it ends.
// A finished result sits in the output register, and the next beat is taken
// while it waits; write back of that next beat holds until the slot frees up.
module page_bitmap_refcount_allocator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [pbra_pkg::IN_DATA_W-1:0]   s_tdata,  // page_index[11:0], zero fill
	input  logic [pbra_pkg::IN_USER_W-1:0]   s_tuser,  // mode[2:0]
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [pbra_pkg::OUT_DATA_W-1:0]  m_tdata,  // result_page, ref_count, free_pages
	output logic [pbra_pkg::OUT_USER_W-1:0]  m_tuser   // status[1:0]
);

	import pbra_pkg::*;

	// Priority encoder: index of the lowest set bit of a map word (31 if none).
	function automatic logic [BIT_W-1:0] lowest32(input logic [MAP_BITS-1:0] w);
		logic [BIT_W-1:0] idx;
		idx = BIT_W'(MAP_BITS - 1);
		for (int i = MAP_BITS - 1; i >= 0; i--) begin
			if (w[i]) begin
				idx = BIT_W'(i);
			end
		end
		return idx;
	endfunction

	function automatic logic [GRP_W-1:0] lowest_grp(input logic [GRP_N-1:0] g);
		logic [GRP_W-1:0] idx;
		idx = GRP_W'(GRP_N - 1);
		for (int i = GRP_N - 1; i >= 0; i--) begin
			if (g[i]) begin
				idx = GRP_W'(i);
			end
		end
		return idx;
	endfunction

	state_t state_q, state_d;

	logic [MODE_W-1:0]    mode_q;
	logic [PAGE_W-1:0]    page_q;
	logic [GRP_W-1:0]     grp_q;
	logic [WORD_W-1:0]    word_q;
	logic [PAGE_W-1:0]    clr_q;
	logic [MAP_WORDS-1:0] summ_q;   // one bit per map word: word has a free page
	logic [FREE_W-1:0]    fcount_q;

	logic                  m_tvalid_q;
	logic [STATUS_W-1:0]   status_q;
	logic [PAGE_W-1:0]     rpage_q;
	logic [COUNT_W-1:0]    rcount_q;
	logic [FREE_W-1:0]     rfree_q;

	// Memory ports.
	logic                  map_we, map_re;
	logic [WORD_W-1:0]     map_waddr, map_raddr;
	logic [MAP_BITS-1:0]   map_wdata, map_rdata;
	logic                  ref_we, ref_re;
	logic [PAGE_W-1:0]     ref_waddr, ref_raddr;
	logic [COUNT_W-1:0]    ref_wdata, ref_rdata;

	pbra_ram #(.WIDTH(MAP_BITS), .DEPTH(MAP_WORDS)) u_map_ram (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.re    (map_re),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	pbra_ram #(.WIDTH(COUNT_W), .DEPTH(PAGE_TOTAL)) u_ref_ram (
		.clk   (clk),
		.we    (ref_we),
		.waddr (ref_waddr),
		.wdata (ref_wdata),
		.re    (ref_re),
		.raddr (ref_raddr),
		.rdata (ref_rdata)
	);

	logic in_fire, out_free;
	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// Alloc search: first group of 32 words holding a free page, then the word.
	logic [GRP_N-1:0]    grp_nz;
	logic [MAP_BITS-1:0] grp_slice;
	logic [WORD_W-1:0]   word_sel;

	always_comb begin
		for (int g = 0; g < GRP_N; g++) begin
			grp_nz[g] = |summ_q[g*MAP_BITS +: MAP_BITS];
		end
	end

	assign grp_slice = summ_q[{grp_q, BIT_W'(0)} +: MAP_BITS];
	assign word_sel  = {grp_q, lowest32(grp_slice)};

	// Alloc write back: take the lowest free bit of the fetched word.
	logic [BIT_W-1:0]    a_bit;
	logic [MAP_BITS-1:0] a_word;
	assign a_bit  = lowest32(map_rdata);
	assign a_word = map_rdata & ~(MAP_BITS'(1) << a_bit);

	// Read-modify-write of a page's count and free bit.
	logic [BIT_W-1:0]    r_bit;
	logic [MAP_BITS-1:0] r_mask;
	logic                r_isfree, r_newbit, mk_free, mk_used;
	logic [COUNT_W-1:0]  r_count;
	logic [STATUS_W-1:0] r_status;
	logic [MAP_BITS-1:0] r_word;
	logic [FREE_W-1:0]   r_free;

	assign r_bit    = page_q[BIT_W-1:0];
	assign r_mask   = MAP_BITS'(1) << r_bit;
	assign r_isfree = map_rdata[r_bit];

	always_comb begin
		r_count  = ref_rdata;
		r_status = STATUS_OK;
		mk_free  = 1'b0;
		mk_used  = 1'b0;
		case (mode_q)
			MODE_REF: begin
				if (ref_rdata != COUNT_MAX) begin
					r_count = ref_rdata + COUNT_W'(1);
				end
			end
			MODE_UNREF: begin
				if (ref_rdata == '0) begin
					r_status = STATUS_UNDER;
				end else if (ref_rdata != COUNT_MAX) begin
					r_count = ref_rdata - COUNT_W'(1);
					mk_free = (ref_rdata == COUNT_W'(1));
				end
			end
			MODE_AVAIL: begin
				r_count = '0;
				mk_free = 1'b1;
			end
			MODE_RESERVE: begin
				r_count = COUNT_MAX;
				mk_used = 1'b1;
			end
			default: begin
			end
		endcase
		r_newbit = mk_free ? 1'b1 : (mk_used ? 1'b0 : r_isfree);
		r_word   = (map_rdata & ~r_mask) | (r_newbit ? r_mask : '0);
		if (mk_free && !r_isfree) begin
			r_free = fcount_q + FREE_W'(1);
		end else if (mk_used && r_isfree) begin
			r_free = fcount_q - FREE_W'(1);
		end else begin
			r_free = fcount_q;
		end
	end

	// Sequencer and memory port control.
	logic                out_load;
	logic [STATUS_W-1:0] o_status;
	logic [PAGE_W-1:0]   o_page;
	logic [COUNT_W-1:0]  o_count;
	logic [FREE_W-1:0]   o_free;

	always_comb begin
		state_d   = state_q;
		map_we    = 1'b0;
		map_waddr = word_q;
		map_wdata = a_word;
		map_re    = 1'b0;
		map_raddr = s_tdata[PAGE_W-1:BIT_W];
		ref_we    = 1'b0;
		ref_waddr = page_q;
		ref_wdata = r_count;
		ref_re    = 1'b0;
		ref_raddr = s_tdata[PAGE_W-1:0];
		out_load  = 1'b0;
		o_status  = STATUS_OK;
		o_page    = page_q;
		o_count   = r_count;
		o_free    = r_free;
		unique case (state_q)
			ST_CLEAR: begin
				// Every page starts reserved: count 255, not in the free map.
				map_we    = 1'b1;
				map_waddr = clr_q[WORD_W-1:0];
				map_wdata = '0;
				ref_we    = 1'b1;
				ref_waddr = clr_q;
				ref_wdata = COUNT_MAX;
				if (clr_q == PAGE_W'(PAGE_TOTAL - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_fire) begin
					if (s_tuser == MODE_ALLOC) begin
						state_d = ST_AGRP;
					end else begin
						map_re  = 1'b1;
						ref_re  = 1'b1;
						state_d = ST_RMW;
					end
				end
			end
			ST_AGRP: begin
				if (grp_nz == '0) begin
					// Out of pages: report and leave everything as it is.
					o_status = STATUS_NOMEM;
					o_page   = '0;
					o_count  = '0;
					o_free   = fcount_q;
					if (out_free) begin
						out_load = 1'b1;
						state_d  = ST_IDLE;
					end
				end else begin
					state_d = ST_AWORD;
				end
			end
			ST_AWORD: begin
				map_re    = 1'b1;
				map_raddr = word_sel;
				state_d   = ST_AWR;
			end
			ST_AWR: begin
				o_page  = {word_q, a_bit};
				o_count = COUNT_W'(1);
				o_free  = fcount_q - FREE_W'(1);
				if (out_free) begin
					map_we    = 1'b1;
					ref_we    = 1'b1;
					ref_waddr = {word_q, a_bit};
					ref_wdata = COUNT_W'(1);
					out_load  = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			ST_RMW: begin
				o_status = r_status;
				map_waddr = page_q[PAGE_W-1:BIT_W];
				map_wdata = r_word;
				if (out_free) begin
					map_we   = 1'b1;
					ref_we   = 1'b1;
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			summ_q   <= '0;
			fcount_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + PAGE_W'(1);
			end
			if (state_q == ST_AWR && out_free) begin
				summ_q[word_q] <= |a_word;
				fcount_q       <= fcount_q - FREE_W'(1);
			end
			if (state_q == ST_RMW && out_free) begin
				summ_q[page_q[PAGE_W-1:BIT_W]] <= |r_word;
				fcount_q                       <= r_free;
			end
		end
	end

	// Item and search registers, loaded as a beat moves through the sequencer.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_q <= s_tuser;
			page_q <= s_tdata[PAGE_W-1:0];
		end
		if (state_q == ST_AGRP) begin
			grp_q <= lowest_grp(grp_nz);
		end
		if (state_q == ST_AWORD) begin
			word_q <= word_sel;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q <= o_status;
			rpage_q  <= o_page;
			rcount_q <= o_count;
			rfree_q  <= o_free;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {(OUT_DATA_W - PAGE_W - COUNT_W - FREE_W)'(0), rfree_q, rcount_q, rpage_q};

endmodule

/* src/pbra_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
module pbra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* tb/page_bitmap_refcount_allocator_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the page bitmap refcount allocator.
module page_bitmap_refcount_allocator_tb;

	import pbra_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam int PHASE_ITEMS  = 104;

	// One expected result beat, as the block should report it.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [PAGE_W-1:0]   page;
		logic [COUNT_W-1:0]  count;
		logic [FREE_W-1:0]   free_pages;
	} outcome_t;

	// Shadow copy of the allocator state plus the queue of outcomes that the
	// block still owes us. Requests are applied in accept order, results are
	// compared in arrival order.
	class page_ledger;
		bit [PAGE_TOTAL-1:0] free_map;
		logic [COUNT_W-1:0]  refs [PAGE_TOTAL];
		int                  free_total;
		outcome_t            owed [$];
		int                  errors;

		function new();
			free_map   = '0;
			free_total = 0;
			errors     = 0;
			foreach (refs[i])
				refs[i] = COUNT_MAX;
		endfunction

		function void mark_free(int p);
			if (!free_map[p]) begin
				free_map[p] = 1'b1;
				free_total++;
			end
		endfunction

		function void mark_used(int p);
			if (free_map[p]) begin
				free_map[p] = 1'b0;
				free_total--;
			end
		endfunction

		// Works out what one accepted request does to the state and what it reports.
		function void note_request(logic [MODE_W-1:0] mode, logic [PAGE_W-1:0] pg);
			outcome_t o;
			int       c;
			o.status = STATUS_OK;
			o.page   = pg;
			o.count  = '0;
			if (mode == MODE_ALLOC) begin
				// Lowest free page wins; with none free the request fails.
				o.status = STATUS_NOMEM;
				o.page   = '0;
				for (int p = 0; p < PAGE_TOTAL; p++) begin
					if (free_map[p]) begin
						mark_used(p);
						refs[p]  = 8'd1;
						o.status = STATUS_OK;
						o.page   = p[PAGE_W-1:0];
						o.count  = 8'd1;
						break;
					end
				end
			end else begin
				c = refs[pg];
				case (mode)
					MODE_REF: begin
						if (c < COUNT_MAX)
							c++;
					end
					MODE_UNREF: begin
						// A saturated count is sticky; a zero count is flagged.
						if (c == 0)
							o.status = STATUS_UNDER;
						else if (c < COUNT_MAX) begin
							c--;
							if (c == 0)
								mark_free(pg);
						end
					end
					MODE_AVAIL: begin
						c = 0;
						mark_free(pg);
					end
					MODE_RESERVE: begin
						c = COUNT_MAX;
						mark_used(pg);
					end
					default: ;
				endcase
				refs[pg] = c[COUNT_W-1:0];
				o.count  = c[COUNT_W-1:0];
			end
			o.free_pages = free_total[FREE_W-1:0];
			owed.push_back(o);
		endfunction

		function void compare(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				if (errors < 10)
					$display("%0t: wrong %s, expected %0d, got %0d", $realtime, field, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [STATUS_W-1:0] st, logic [OUT_DATA_W-1:0] data);
			outcome_t e;
			if (owed.size() == 0) begin
				if (errors < 10)
					$display("%0t: result beat with nothing outstanding, tdata %h tuser %0d",
						$realtime, data, st);
				errors++;
				return;
			end
			e = owed.pop_front();
			compare("status", e.status, st);
			compare("result_page", e.page, data[11:0]);
			compare("ref_count", e.count, data[19:12]);
			compare("free_pages", e.free_pages, data[32:20]);
		endfunction
	endclass

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;   // page_index[11:0], zero fill
	logic [IN_USER_W-1:0]  s_tuser  = '0;   // mode[2:0]
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;         // result_page, ref_count, free_pages
	logic [OUT_USER_W-1:0] m_tuser;         // status[1:0]

	// Pacing knobs, in percent of cycles.
	int   idle_pct  = 0;
	int   stall_pct = 0;
	logic hold_req  = 1'b0;
	int   hold_left = 0;
	int   cycles    = 0;
	int   beats_sent = 0;

	page_ledger ledger = new();

	page_bitmap_refcount_allocator DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Result side: random back-pressure, plus one long hold-off on request so
	// that the block fills up and has to refuse input for a while.
	always @(posedge clk) begin
		if (hold_req)
			hold_left = HOLD_CYCLES;
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Both handshakes are sampled here with the values from before the edge.
	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			ledger.note_request(s_tuser, s_tdata[PAGE_W-1:0]);
		if (m_tvalid && m_tready)
			ledger.check_result(m_tuser, m_tdata);
	end

	// Offers one beat, after a random gap, and returns at the edge that takes it.
	task automatic send_beat(input logic [MODE_W-1:0] mode, input int pg);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {{(IN_DATA_W-PAGE_W){1'b0}}, pg[PAGE_W-1:0]};
		do
			@(posedge clk);
		while (!s_tready);
		beats_sent++;
	endtask

	// Mostly a small, busy pool of low pages so that counts and the bitmap see
	// real traffic; some top pages and some anywhere to toggle every address bit.
	function automatic int pick_page();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return $urandom_range(0, 47);
		else if (r < 80)
			return $urandom_range(PAGE_TOTAL - 32, PAGE_TOTAL - 1);
		return $urandom_range(0, PAGE_TOTAL - 1);
	endfunction

	function automatic logic [MODE_W-1:0] pick_mode();
		int r;
		r = $urandom_range(99);
		if (r < 25)
			return MODE_ALLOC;
		else if (r < 45)
			return MODE_REF;
		else if (r < 70)
			return MODE_UNREF;
		else if (r < 85)
			return MODE_AVAIL;
		else if (r < 93)
			return MODE_RESERVE;
		return MODE_W'($urandom_range(5, 7));
	endfunction

	initial begin
		int p;
		int k;
		int phase_start;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. Right after reset every page is reserved at 255.
		send_beat(MODE_ALLOC, 0);            // nothing free yet
		send_beat(MODE_UNREF, 100);          // saturated count is left alone
		send_beat(MODE_REF, 100);            // and cannot go higher
		send_beat(MODE_AVAIL, 4095);
		send_beat(MODE_AVAIL, 0);
		send_beat(MODE_AVAIL, 0);            // already free, count must not move
		send_beat(MODE_ALLOC, 0);            // takes page 0
		send_beat(MODE_REF, 0);
		send_beat(MODE_UNREF, 0);
		send_beat(MODE_UNREF, 0);            // drops to zero and frees the page
		send_beat(MODE_UNREF, 0);            // zero count is flagged
		send_beat(MODE_REF, 4095);           // free page gains a count, stays free
		send_beat(MODE_RESERVE, 4095);
		send_beat(MODE_RESERVE, 4095);       // reserving a used page again
		send_beat(3'd5, 4095);
		send_beat(3'd6, 0);
		send_beat(3'd7, 2730);
		send_beat(MODE_AVAIL, 2730);
		send_beat(MODE_AVAIL, 1365);
		send_beat(MODE_ALLOC, 0);            // page 0 again, the lowest
		send_beat(MODE_ALLOC, 0);            // then 1365
		send_beat(MODE_ALLOC, 0);            // then 2730
		send_beat(MODE_ALLOC, 0);            // empty again
		send_beat(MODE_AVAIL, 32);
		send_beat(MODE_AVAIL, 31);           // across a map word boundary
		send_beat(MODE_ALLOC, 0);

		// Random part in four pacing phases. The first opens with a long
		// result-side hold-off while input keeps coming.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct <= 0;  stall_pct <= 0;  end
				1: begin idle_pct <= 82; stall_pct <= 0;  end
				2: begin idle_pct <= 0;  stall_pct <= 82; end
				default: begin idle_pct <= 15; stall_pct <= 15; end
			endcase
			if (phase == 0) begin
				hold_req <= 1'b1;
				@(posedge clk);
				hold_req <= 1'b0;
			end
			phase_start = beats_sent;
			while (beats_sent - phase_start < PHASE_ITEMS) begin
				if ($urandom_range(99) < 60) begin
					// Life of one page: seed it, maybe let alloc take something,
					// raise its count and drop it back, sometimes past zero, now and then reserve it.
					p = pick_page();
					k = $urandom_range(0, 3);
					send_beat(MODE_AVAIL, p);
					if ($urandom_range(1))
						send_beat(MODE_ALLOC, pick_page());
					for (int i = 0; i < k; i++)
						send_beat(MODE_REF, p);
					for (int i = $urandom_range(0, k + 2); i > 0; i--)
						send_beat(MODE_UNREF, p);
					if ($urandom_range(9) == 0)
						send_beat(MODE_RESERVE, p);
				end else begin
					send_beat(pick_mode(), pick_page());
				end
			end
		end
		s_tvalid <= 1'b0;

		while (ledger.owed.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (ledger.errors == 0 && ledger.owed.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
